FILE: rtl/chunk_container_walker_core_macros.svh
// Assertion macros for the chunk container walker.
// Used by the top level; depends on a clock named clk and a reset named rst_n.
`ifndef CHUNK_CONTAINER_WALKER_CORE_MACROS_SVH
`define CHUNK_CONTAINER_WALKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ccw_pkg.sv
// Shared types and constants for the chunk container walker.
// No dependencies; imported by every module of the block.
package ccw_pkg;

    localparam int CURSOR_W     = 32;
    localparam int COUNT_W      = 16;
    localparam int FIELD_BYTES  = 4;
    localparam int HEADER_BYTES = 8;

    // Result status codes.
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_WANTED_TAG  = 1'b0;
    localparam logic CFG_MATCH_INDEX = 1'b1;

    typedef enum logic [3:0] {
        PH_HEADER = 4'b0001,
        PH_TAG    = 4'b0010,
        PH_SIZE   = 4'b0100,
        PH_SKIP   = 4'b1000
    } walk_phase_t;

    typedef struct packed {
        walk_phase_t         phase;
        logic [2:0]          fbc;
        logic [CURSOR_W-1:0] total;
        logic [CURSOR_W-1:0] cursor;
        logic [CURSOR_W-1:0] size;
        logic [CURSOR_W-1:0] skip;
        logic                mismatch;
        logic [COUNT_W-1:0]  matches_left;
        logic                done;
    } walk_state_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [CURSOR_W-1:0] offset;
    } walk_result_t;

endpackage

FILE: rtl/ccw_step.sv
// Next-state and result logic for one container byte.
// Depends on ccw_pkg for the walk state and result types.
module ccw_step
    import ccw_pkg::*;
(
    input  walk_state_t         st,
    input  logic [7:0]          data_byte,
    input  logic                buffer_start,
    input  logic                buffer_end,
    input  logic [31:0]         wanted_tag,
    input  logic [COUNT_W-1:0]  match_index,
    output walk_state_t         st_next,
    output logic                res_valid,
    output walk_result_t        res
);

    logic                at_boundary;
    logic                no_trunc;
    logic                mismatch_now;
    logic [7:0]          tag_byte;
    logic [CURSOR_W-1:0] size_now;
    logic [CURSOR_W:0]   tag_sum;
    logic [CURSOR_W:0]   size_sum;

    always_comb
    begin
        st_next       = st;
        res_valid     = 1'b0;
        res.status    = ST_FOUND;
        res.offset    = '0;
        at_boundary   = 1'b0;
        no_trunc      = 1'b0;
        mismatch_now  = 1'b0;
        tag_byte      = '0;
        size_now      = '0;
        tag_sum       = '0;
        size_sum      = '0;

        if (buffer_start)
        begin
            st_next.phase        = PH_HEADER;
            st_next.fbc          = '0;
            st_next.total        = '0;
            st_next.cursor       = '0;
            st_next.size         = '0;
            st_next.skip         = '0;
            st_next.mismatch     = 1'b0;
            st_next.matches_left = match_index;
            st_next.done         = 1'b0;
        end

        if (!st_next.done)
        begin
            unique case (st_next.phase)
                PH_HEADER:
                begin
                    // Bytes 4 to 7 carry the big-endian total length.
                    if (st_next.fbc[2])
                        st_next.total = {st_next.total[CURSOR_W-9:0], data_byte};
                    if (st_next.fbc == 3'(HEADER_BYTES - 1))
                    begin
                        st_next.fbc    = '0;
                        st_next.cursor = '0;
                        at_boundary    = 1'b1;
                    end
                    else
                        st_next.fbc = st_next.fbc + 3'd1;
                end
                PH_TAG:
                begin
                    case (st_next.fbc[1:0])
                        2'd0:    tag_byte = wanted_tag[31:24];
                        2'd1:    tag_byte = wanted_tag[23:16];
                        2'd2:    tag_byte = wanted_tag[15:8];
                        default: tag_byte = wanted_tag[7:0];
                    endcase
                    mismatch_now     = st_next.mismatch | (data_byte != tag_byte);
                    st_next.mismatch = mismatch_now;
                    tag_sum = {1'b0, st_next.cursor} + (CURSOR_W+1)'(FIELD_BYTES);
                    if (st_next.fbc[1:0] == 2'(FIELD_BYTES - 1))
                    begin
                        st_next.fbc = '0;
                        if (!mismatch_now && st_next.matches_left == '0)
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_FOUND;
                            res.offset = st_next.cursor;
                        end
                        else
                        begin
                            if (!mismatch_now)
                                st_next.matches_left = st_next.matches_left - COUNT_W'(1);
                            if (tag_sum[CURSOR_W])
                            begin
                                res_valid  = 1'b1;
                                res.status = ST_OVERFLOW;
                            end
                            else
                            begin
                                st_next.cursor = tag_sum[CURSOR_W-1:0];
                                st_next.size   = '0;
                                st_next.phase  = PH_SIZE;
                            end
                        end
                    end
                    else
                        st_next.fbc = st_next.fbc + 3'd1;
                end
                PH_SIZE:
                begin
                    size_now     = {st_next.size[CURSOR_W-9:0], data_byte};
                    st_next.size = size_now;
                    size_sum = {1'b0, st_next.cursor} + {1'b0, size_now}
                             + (CURSOR_W+1)'(FIELD_BYTES);
                    if (st_next.fbc[1:0] == 2'(FIELD_BYTES - 1))
                    begin
                        st_next.fbc = '0;
                        if (size_sum[CURSOR_W])
                        begin
                            res_valid  = 1'b1;
                            res.status = ST_OVERFLOW;
                        end
                        else
                        begin
                            st_next.cursor = size_sum[CURSOR_W-1:0];
                            st_next.skip   = size_now;
                            if (size_now == '0)
                                at_boundary = 1'b1;
                            else
                                st_next.phase = PH_SKIP;
                        end
                    end
                    else
                        st_next.fbc = st_next.fbc + 3'd1;
                end
                PH_SKIP:
                begin
                    if (st_next.skip != '0)
                        st_next.skip = st_next.skip - CURSOR_W'(1);
                    if (st_next.skip == '0)
                        at_boundary = 1'b1;
                end
                default:
                begin
                    st_next.done = 1'b1;
                    no_trunc     = 1'b1;
                end
            endcase

            // Chunk boundary: end of the chunk area or start of the next tag.
            if (at_boundary)
            begin
                if (st_next.cursor >= st_next.total)
                begin
                    res_valid  = 1'b1;
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    st_next.phase    = PH_TAG;
                    st_next.fbc      = '0;
                    st_next.mismatch = 1'b0;
                end
            end

            if (!res_valid && buffer_end && !no_trunc)
            begin
                res_valid  = 1'b1;
                res.status = ST_TRUNCATED;
            end

            if (res_valid)
            begin
                st_next.done = 1'b1;
                if (res.status != ST_FOUND)
                    res.offset = '0;
            end
        end
    end

endmodule

FILE: rtl/ccw_out_fifo.sv
// Two-entry result queue that decouples the walker from the result consumer.
// Depends on ccw_pkg for the result type.
module ccw_out_fifo
    import ccw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  walk_result_t push_data,
    output logic         full,
    output logic         pop_valid,
    input  logic         pop_ready,
    output walk_result_t pop_data
);

    walk_result_t slot_reg [2];
    logic         wr_ptr_reg;
    logic         wr_ptr_next;
    logic         rd_ptr_reg;
    logic         rd_ptr_next;
    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    logic         pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: rtl/chunk_container_walker_core.sv
// Top level of the chunk container walker: input register, walk state and result queue.
// Depends on ccw_pkg, ccw_step, ccw_out_fifo and chunk_container_walker_core_macros.svh.

// The walker takes one container byte per cycle with no gaps required between
// transactions, and at most one result comes out per buffer. A byte sits in the input
// register while the combinational state update runs, and its result, if any, is written
// into the result queue, from which it is visible on the output. The input side stalls
// only while the two-entry result queue is full, so one byte per cycle is sustained
// as long as results are taken. Configuration writes are accepted in every cycle;
// match_index takes effect at the next buffer start, wanted_tag on every tag byte.
`include "chunk_container_walker_core_macros.svh"

module chunk_container_walker_core
    import ccw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                buffer_start,
    input  logic                buffer_end,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic [31:0]         chunk_offset,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [31:0]        wanted_tag_reg;
    logic [COUNT_W-1:0] match_index_reg;

    logic               in_vld_reg;
    logic               in_vld_next;
    logic [7:0]         byte_reg;
    logic               start_reg;
    logic               end_reg;

    walk_state_t        st_reg;
    walk_state_t        st_next;
    logic               step_res_valid;
    walk_result_t       step_res;

    logic               fifo_full;
    logic               advance;
    logic               push;
    walk_result_t       out_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !(in_vld_reg && fifo_full);
    assign advance   = in_vld_reg && !fifo_full;
    assign push      = advance && step_res_valid;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && in_ready)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_tag_reg  <= '0;
            match_index_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WANTED_TAG:  wanted_tag_reg  <= cfg_data;
                CFG_MATCH_INDEX: match_index_reg <= cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            st_reg     <= '{phase: PH_HEADER, fbc: '0, total: '0, cursor: '0, size: '0,
                            skip: '0, mismatch: 1'b0, matches_left: '0, done: 1'b1};
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            start_reg <= buffer_start;
            end_reg   <= buffer_end;
        end
    end

    ccw_step u_step (
        .st           (st_reg),
        .data_byte    (byte_reg),
        .buffer_start (start_reg),
        .buffer_end   (end_reg),
        .wanted_tag   (wanted_tag_reg),
        .match_index  (match_index_reg),
        .st_next      (st_next),
        .res_valid    (step_res_valid),
        .res          (step_res)
    );

    ccw_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (step_res),
        .full      (fifo_full),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (out_res)
    );

    assign status       = out_res.status;
    assign chunk_offset = out_res.offset;

    // A delivered result always ends the walk.
    `CCW_ASSERT_NEXT(a_done_after_result, push, st_reg.done, "walk not idle after result")
    // Bytes that arrive while the walk is idle produce nothing.
    `CCW_ASSERT_SAME(a_idle_quiet, advance && st_reg.done && !start_reg, !step_res_valid,
        "result from an idle walker")
    // Only a found result carries an offset.
    `CCW_ASSERT_SAME(a_offset_zero, out_valid && status != ST_FOUND, chunk_offset == '0,
        "nonzero offset on a result other than found")

endmodule

FILE: verif/chunk_container_walker_core_tb.sv
// Self-checking testbench for chunk_container_walker_core: streams container buffers,
// predicts each walk result in a scoreboard class and compares the results.
// Depends on ccw_pkg and the RTL of the walker.

module chunk_container_walker_core_tb
    import ccw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Tracks the walk state byte by byte and holds the results still owed by the block.
    class walk_scoreboard;
        logic [31:0]  tag_want;
        logic [15:0]  nth_want;
        walk_phase_t  phase;
        logic [2:0]   fbc;
        logic [31:0]  total;
        logic [31:0]  cursor;
        logic [31:0]  size_acc;
        logic [31:0]  skip;
        logic         mismatch;
        logic         done;
        logic [15:0]  left;
        walk_result_t pending_reports[$];
        int           errors;
        int           seen[4];

        function new();
            tag_want = '0;
            nth_want = '0;
            phase    = PH_HEADER;
            fbc      = '0;
            total    = '0;
            cursor   = '0;
            size_acc = '0;
            skip     = '0;
            mismatch = 1'b0;
            left     = '0;
            done     = 1'b1;
            errors   = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == CFG_WANTED_TAG)
                tag_want = val;
            else
                nth_want = val[15:0];
        endfunction

        function bit finish(logic [1:0] st, logic [31:0] off);
            walk_result_t r;
            r.status = st;
            r.offset = off;
            pending_reports.push_back(r);
            done = 1'b1;
            return 1'b1;
        endfunction

        // A chunk starts here unless the cursor has reached the total length.
        function bit boundary();
            if (cursor >= total)
                return finish(ST_NOT_FOUND, '0);
            phase    = PH_TAG;
            fbc      = '0;
            mismatch = 1'b0;
            return 1'b0;
        endfunction

        function void walk_byte(logic [7:0] b, logic s, logic e);
            bit          hit;
            int          sh;
            logic [32:0] nxt;
            hit = 1'b0;
            if (s)
            begin
                phase    = PH_HEADER;
                fbc      = '0;
                total    = '0;
                cursor   = '0;
                size_acc = '0;
                skip     = '0;
                mismatch = 1'b0;
                left     = nth_want;
                done     = 1'b0;
            end
            if (done)
                return;
            case (phase)
                PH_HEADER:
                begin
                    if (fbc >= 3'd4)
                        total = {total[23:0], b};
                    fbc = fbc + 3'd1;
                    if (fbc == 3'd0)
                    begin
                        cursor = '0;
                        hit = boundary();
                    end
                end
                PH_TAG:
                begin
                    sh = 8 * (3 - fbc[1:0]);
                    if (b != tag_want[sh +: 8])
                        mismatch = 1'b1;
                    fbc = {1'b0, fbc[1:0] + 2'd1};
                    if (fbc == 3'd0)
                    begin
                        if (!mismatch && left == 16'd0)
                            hit = finish(ST_FOUND, cursor);
                        else
                        begin
                            if (!mismatch)
                                left = left - 16'd1;
                            if (cursor > 32'hFFFF_FFFB)
                                hit = finish(ST_OVERFLOW, '0);
                            else
                            begin
                                cursor   = cursor + 32'd4;
                                size_acc = '0;
                                phase    = PH_SIZE;
                            end
                        end
                    end
                end
                PH_SIZE:
                begin
                    size_acc = {size_acc[23:0], b};
                    fbc = {1'b0, fbc[1:0] + 2'd1};
                    if (fbc == 3'd0)
                    begin
                        nxt = {1'b0, cursor} + {1'b0, size_acc} + 33'd4;
                        if (nxt[32])
                            hit = finish(ST_OVERFLOW, '0);
                        else
                        begin
                            cursor = nxt[31:0];
                            skip   = size_acc;
                            if (skip == 32'd0)
                                hit = boundary();
                            else
                                phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (skip != 32'd0)
                        skip = skip - 32'd1;
                    if (skip == 32'd0)
                        hit = boundary();
                end
                default:
                begin
                    done = 1'b1;
                    return;
                end
            endcase
            if (!hit && e)
                hit = finish(ST_TRUNCATED, '0);
        endfunction

        function void check_report(logic [1:0] st, logic [31:0] off);
            walk_result_t want;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result: status %0d chunk_offset 0x%08h", st, off);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            seen[want.status]++;
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (off !== want.offset)
            begin
                $error("chunk_offset: expected 0x%08h, actual 0x%08h", want.offset, off);
                errors++;
            end
        endfunction

        function void final_check();
            if (pending_reports.size() != 0)
            begin
                $error("%0d results never arrived", pending_reports.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        buffer_start;
    logic        buffer_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] chunk_offset;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    walk_scoreboard board = new();
    logic [7:0]     image[$];
    bit             steady;
    int             bytes_sent;
    int             containers;

    chunk_container_walker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .buffer_start (buffer_start),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chunk_offset (chunk_offset),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 27);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s, input logic e);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        buffer_start <= s;
        buffer_end   <= e;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.walk_byte(b, s, e);
        bytes_sent++;
    endtask

    // Writes both registers back to back; valid drops only after the second transaction.
    task automatic set_config(input logic [31:0] tag, input logic [15:0] nth);
        logic [31:0] nth_word;
        nth_word = {16'($urandom()), nth};
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WANTED_TAG;
        cfg_data  <= tag;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(CFG_WANTED_TAG, tag);
        cfg_index <= CFG_MATCH_INDEX;
        cfg_data  <= nth_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(CFG_MATCH_INDEX, nth_word);
        cfg_valid <= 1'b0;
    endtask

    // Waits for every owed result, then lets bytes still in the pipeline drain.
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0 && waited < 4000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    function automatic void put_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            image.push_back(w[8*k +: 8]);
    endfunction

    function automatic void load_header(logic [31:0] total_len);
        image.delete();
        put_word($urandom());
        put_word(total_len);
    endfunction

    task automatic play_image(input int end_at);
        containers++;
        for (int i = 0; i < image.size(); i++)
            send_byte(image[i], i == 0, i == end_at);
    endtask

    // Random container: mostly small chunks, tags that match, nearly match or not,
    // and a total length that fits the chunks, falls short, runs over or is huge.
    function automatic void build_container(logic [31:0] tag);
        int          chunks;
        int          roll;
        int          area;
        int          k;
        logic [31:0] t;
        logic [31:0] sz;
        logic [31:0] tot;
        load_header(32'd0);
        chunks = $urandom_range(4);
        for (int c = 0; c < chunks; c++)
        begin
            roll = $urandom_range(99);
            t = tag;
            if (roll >= 65)
                t = $urandom();
            else if (roll >= 45)
            begin
                k = $urandom_range(3);
                t[8*k +: 8] = t[8*k +: 8] ^ (8'h01 << $urandom_range(7));
            end
            put_word(t);
            roll = $urandom_range(99);
            if (roll < 80)
                sz = $urandom_range(5);
            else if (roll < 95)
                sz = $urandom_range(40, 6);
            else
                sz = $urandom();
            put_word(sz);
            for (int p = 0; p < sz && p < 41; p++)
                image.push_back(8'($urandom()));
            if (sz > 32'd40)
                break;
        end
        area = image.size() - 8;
        roll = $urandom_range(99);
        if (roll < 55)
            tot = area;
        else if (roll < 70)
            tot = $urandom_range(area);
        else if (roll < 85)
            tot = area + $urandom_range(6, 1);
        else if (roll < 93)
            tot = '0;
        else
            tot = $urandom();
        for (int j = 0; j < 4; j++)
            image[4 + j] = tot[8*(3-j) +: 8];
    endfunction

    task automatic run_phase(input int budget);
        int stop;
        int roll;
        int end_at;
        stop = bytes_sent + budget;
        while (bytes_sent < stop)
        begin
            if ($urandom_range(99) < 6)
                send_byte(8'($urandom()), $urandom_range(9) == 0, $urandom_range(3) == 0);
            else
            begin
                build_container(board.tag_want);
                roll = $urandom_range(99);
                end_at = image.size() - 1;
                if (roll >= 90)
                    end_at = -1;
                else if (roll >= 75)
                begin
                    end_at = $urandom_range(image.size() - 1);
                    while (image.size() > end_at + 3)
                        void'(image.pop_back());
                end
                play_image(end_at);
            end
        end
    endtask

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_report(status, chunk_offset);
            out_ready <= steady || ($urandom_range(99) >= 27);
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        buffer_start <= 1'b0;
        buffer_end   <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= CFG_WANTED_TAG;
        cfg_data     <= '0;
        steady       = 1'b0;
        bytes_sent   = 0;
        containers   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(32'h6461_7461, 16'd0);
        // No walk has started yet, so these are dropped.
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        // Start and end on one byte.
        send_byte(8'hA5, 1'b1, 1'b1);
        load_header(32'd0);
        play_image(-1);
        send_byte(8'h5A, 1'b0, 1'b1);
        // Total of two: the tag still gets compared and matches, end on the same byte.
        load_header(32'd2);
        put_word(32'h6461_7461);
        play_image(11);
        load_header(32'd8);
        put_word(32'h6461_7400);
        put_word(32'd0);
        play_image(15);
        settle();

        set_config(32'h6461_7461, 16'd1);
        load_header(32'd28);
        put_word(32'h6461_7461);
        put_word(32'd2);
        image.push_back(8'h00);
        image.push_back(8'hFF);
        put_word(32'h0000_0000);
        put_word(32'd0);
        put_word(32'h6461_7461);
        put_word(32'd0);
        play_image(image.size() - 1);
        load_header(32'hFFFF_FFFF);
        put_word(32'd0);
        put_word(32'hFFFF_FFFC);
        play_image(-1);
        // The cursor lands exactly on the 32-bit limit, so the walk carries on.
        load_header(32'hFFFF_FFFF);
        put_word(32'd0);
        put_word(32'hFFFF_FFF7);
        image.push_back(8'h12);
        image.push_back(8'h34);
        play_image(image.size() - 1);
        // Left open; the next buffer start restarts the walk.
        load_header(32'd100);
        put_word(32'd0);
        play_image(-1);
        settle();

        set_config($urandom(), 16'd0);
        run_phase(140);
        settle();
        set_config(32'hFFFF_FFFF, 16'd1);
        run_phase(140);
        settle();
        set_config(32'h0000_0000, 16'd2);
        run_phase(140);
        settle();
        set_config($urandom(), 16'hFFFF);
        run_phase(120);
        settle();
        steady = 1'b1;
        set_config($urandom(), 16'($urandom_range(3)));
        run_phase(140);
        settle();
        steady = 1'b0;
        set_config($urandom(), 16'd0);
        run_phase(140);
        settle();

        board.final_check();
        $display("Sent %0d bytes in %0d containers under eight register settings.",
                 bytes_sent, containers);
        $display("Walk results: %0d found, %0d not found, %0d truncated, %0d overflow.",
                 board.seen[ST_FOUND], board.seen[ST_NOT_FOUND],
                 board.seen[ST_TRUNCATED], board.seen[ST_OVERFLOW]);
        if (board.errors == 0)
            $display("chunk_container_walker_core_tb: clean");
        else
            $display("chunk_container_walker_core_tb: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the walker.");
        $display("chunk_container_walker_core_tb: errors");
        $finish;
    end

endmodule
